// ----- rtl/core/dtapw_pkg.sv -----
// Shared types, codes and the color blend function for the depth-tested pixel writer.
// No dependencies; the front end, back end, top level and checker import it.
package dtapw_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR       = 2'd0,
      OP_PUT_SCREEN  = 2'd1,
      OP_PUT_WORLD   = 2'd2,
      OP_READ_SCREEN = 2'd3
   } op_type;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_X = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_Y = 1'b1;

   // Coordinate arithmetic width: 16-bit difference plus offsets up to 4097.
   localparam int CALC_W = 19;

   localparam logic signed [31:0] DEPTH_MIN    = 32'sh8000_0000;
   localparam logic [7:0]         ALPHA_OPAQUE = 8'd255;
   localparam logic [7:0]         ALPHA_HALF   = 8'd127;
   localparam logic [7:0]         ALPHA_NONE   = 8'd0;

   typedef struct packed {
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic signed [31:0] depth;
      logic [31:0]       id;
   } cell_type;

   localparam cell_type CLEAR_CELL = '{
      red: 8'd0, green: 8'd0, blue: 8'd0, depth: DEPTH_MIN, id: 32'd0
   };

   // Classified request as it travels from the front to the back.
   typedef struct packed {
      op_type            op;
      logic              in_view;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        alpha;
      logic signed [31:0] depth;
      logic [31:0]       id;
   } item_type;

   typedef enum logic [1:0] {
      ST_SWEEP = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EXEC  = 2'd2
   } back_state_type;

   // One color channel: replace, average, or dst + floor((src - dst) * a / 256).
   function automatic logic [7:0] blend_chan(input logic [7:0] src,
                                             input logic [7:0] dst,
                                             input logic [7:0] alpha);
      logic signed [9:0]  diff;
      logic signed [18:0] prod;
      logic [9:0]         sum;
      logic [8:0]         avg;
      logic [7:0]         res;
      diff = $signed({2'b00, src}) - $signed({2'b00, dst});
      prod = diff * $signed({1'b0, alpha});
      sum  = prod[17:8] + {2'b00, dst};
      avg  = {1'b0, src} + {1'b0, dst};
      priority if (alpha == ALPHA_OPAQUE) begin
         res = src;
      end else if (alpha == ALPHA_HALF) begin
         res = avg[8:1];
      end else begin
         res = sum[7:0];
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/dtapw_if.sv -----
// Request and response channel interfaces of the pixel writer.
// Standalone; no package needed.
interface dtapw_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [31:0] depth_in;
   logic [7:0]         src_red;
   logic [7:0]         src_green;
   logic [7:0]         src_blue;
   logic [7:0]         src_alpha;
   logic [31:0]        object_id;

   modport source (output valid, op, coord_x, coord_y, depth_in, src_red, src_green,
                   src_blue, src_alpha, object_id, input ready);
   modport sink   (input valid, op, coord_x, coord_y, depth_in, src_red, src_green,
                   src_blue, src_alpha, object_id, output ready);
endinterface

interface dtapw_rsp_if;
   logic               valid;
   logic               ready;
   logic               written;
   logic               in_view;
   logic [7:0]         cell_red;
   logic [7:0]         cell_green;
   logic [7:0]         cell_blue;
   logic signed [31:0] cell_depth;
   logic [31:0]        cell_id;

   modport source (output valid, written, in_view, cell_red, cell_green, cell_blue,
                   cell_depth, cell_id, input ready);
   modport sink   (input valid, written, in_view, cell_red, cell_green, cell_blue,
                   cell_depth, cell_id, output ready);
endinterface

// ----- rtl/core/dtapw_front.sv -----
// Front end: base point registers, request acceptance, view test and cell address.
// Depends on dtapw_pkg and dtapw_req_if.
module dtapw_front #(
   parameter int VIEW_WIDTH  = 256,
   parameter int VIEW_HEIGHT = 256,
   localparam int ADDR_W     = $clog2(VIEW_WIDTH * VIEW_HEIGHT)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dtapw_req_if.sink                            req_chan,
   input  logic                                 csr_wr_en,
   input  logic [dtapw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dtapw_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic                                 sweeping,
   input  logic                                 q_full,
   output logic                                 push,
   output dtapw_pkg::item_type                  push_item,
   output logic [ADDR_W-1:0]                    push_addr
);
   import dtapw_pkg::*;

   localparam int COL_W  = $clog2(VIEW_WIDTH);
   localparam int ROW_W  = $clog2(VIEW_HEIGHT);
   localparam int HALF_W = VIEW_WIDTH / 2;
   localparam int HALF_H = VIEW_HEIGHT / 2;
   localparam logic signed [CALC_W-1:0] COL_OFS = CALC_W'(HALF_W + 1);
   localparam logic signed [CALC_W-1:0] ROW_OFS = CALC_W'(VIEW_HEIGHT - HALF_H - 2);
   localparam logic signed [CALC_W-1:0] W_LIM   = CALC_W'(VIEW_WIDTH);
   localparam logic signed [CALC_W-1:0] H_LIM   = CALC_W'(VIEW_HEIGHT);

   logic signed [15:0]       base_x_ff;
   logic signed [15:0]       base_y_ff;
   logic signed [CALC_W-1:0] col;
   logic signed [CALC_W-1:0] row;
   op_type                   op;
   logic                     in_view;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= '0;
         base_y_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_X: base_x_ff <= $signed(csr_wr_data);
            CSR_BASE_Y: base_y_ff <= $signed(csr_wr_data);
            default:    base_x_ff <= base_x_ff;
         endcase
      end
   end

   always_comb begin
      op = op_type'(req_chan.op);
      if (op == OP_PUT_WORLD) begin
         // world window: column from the left edge, row counted from the top
         col = CALC_W'(req_chan.coord_x) - CALC_W'(base_x_ff) + COL_OFS;
         row = ROW_OFS - CALC_W'(req_chan.coord_y) + CALC_W'(base_y_ff);
      end else begin
         col = CALC_W'(req_chan.coord_x);
         row = CALC_W'(req_chan.coord_y);
      end
      in_view = (op != OP_CLEAR) && !col[CALC_W-1] && (col < W_LIM)
                && !row[CALC_W-1] && (row < H_LIM);
   end

   assign req_chan.ready = !q_full && !sweeping;
   assign push           = req_chan.valid && req_chan.ready;

   assign push_addr = ADDR_W'(row[ROW_W-1:0]) * ADDR_W'(VIEW_WIDTH)
                      + ADDR_W'(col[COL_W-1:0]);

   always_comb begin
      push_item.op      = op;
      push_item.in_view = in_view;
      push_item.red     = req_chan.src_red;
      push_item.green   = req_chan.src_green;
      push_item.blue    = req_chan.src_blue;
      push_item.alpha   = req_chan.src_alpha;
      push_item.depth   = req_chan.depth_in;
      push_item.id      = req_chan.object_id;
   end

endmodule

// ----- rtl/core/dtapw_queue.sv -----
// Two-entry queue that decouples the front end from the memory back end.
// Depends on nothing but its data width.
module dtapw_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output logic [DATA_W-1:0] data
);
   logic [DATA_W-1:0] entries_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign data  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/dtapw_back.sv -----
// Back end: cell memory, clearing sweep, depth test, blend and response register.
// Depends on dtapw_pkg and dtapw_rsp_if.
module dtapw_back #(
   parameter int VIEW_WIDTH  = 256,
   parameter int VIEW_HEIGHT = 256,
   localparam int ADDR_W     = $clog2(VIEW_WIDTH * VIEW_HEIGHT)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  dtapw_pkg::item_type q_item,
   input  logic [ADDR_W-1:0]   q_addr,
   output logic                q_pop,
   output logic                sweeping,
   dtapw_rsp_if.source         rsp_chan
);
   import dtapw_pkg::*;

   localparam int CELL_COUNT = VIEW_WIDTH * VIEW_HEIGHT;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

   cell_type            mem [CELL_COUNT];

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [ADDR_W-1:0]   sweep_cnt_ff;
   logic [ADDR_W-1:0]   sweep_cnt_in;
   item_type            cur_item_ff;
   logic [ADDR_W-1:0]   cur_addr_ff;
   cell_type            rd_cell_ff;

   logic                out_valid_ff;
   logic                out_written_ff;
   logic                out_in_view_ff;
   cell_type            out_cell_ff;

   logic                out_free;
   logic                load_out;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   cell_type            mem_wdata;

   logic                depth_pass;
   logic                exec_we;
   logic                exec_written;
   cell_type            exec_cell;
   cell_type            exec_out;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: if (sweep_cnt_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE:  if (q_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (out_free) begin
               state_in = (cur_item_ff.op == OP_CLEAR) ? ST_SWEEP : ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      load_out  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = cur_addr_ff;
      mem_wdata = exec_cell;
      sweeping  = 1'b0;
      unique case (state_ff)
         ST_SWEEP: begin
            sweeping  = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_ff;
            mem_wdata = CLEAR_CELL;
         end
         ST_IDLE:  q_pop = q_valid;
         ST_EXEC: begin
            load_out = out_free;
            mem_we   = out_free && exec_we;
         end
         default:  q_pop = 1'b0;
      endcase
   end

   assign sweep_cnt_in = (state_ff == ST_SWEEP) ? sweep_cnt_ff + 1'b1 : '0;

   // depth test and color update on the cell registered when the request was popped
   always_comb begin
      depth_pass   = ($signed(rd_cell_ff.depth) <= $signed(cur_item_ff.depth))
                     && (cur_item_ff.alpha != ALPHA_NONE);
      exec_cell    = rd_cell_ff;
      exec_we      = 1'b0;
      exec_written = 1'b0;
      unique case (cur_item_ff.op)
         OP_CLEAR: exec_written = 1'b1;
         OP_PUT_SCREEN: begin
            if (cur_item_ff.in_view) begin
               exec_cell.red   = cur_item_ff.red;
               exec_cell.green = cur_item_ff.green;
               exec_cell.blue  = cur_item_ff.blue;
               exec_we         = 1'b1;
               exec_written    = 1'b1;
            end
         end
         OP_PUT_WORLD: begin
            if (cur_item_ff.in_view && depth_pass) begin
               exec_cell.red   = blend_chan(cur_item_ff.red, rd_cell_ff.red,
                                            cur_item_ff.alpha);
               exec_cell.green = blend_chan(cur_item_ff.green, rd_cell_ff.green,
                                            cur_item_ff.alpha);
               exec_cell.blue  = blend_chan(cur_item_ff.blue, rd_cell_ff.blue,
                                            cur_item_ff.alpha);
               exec_cell.depth = cur_item_ff.depth;
               exec_cell.id    = cur_item_ff.id;
               exec_we         = 1'b1;
               exec_written    = 1'b1;
            end
         end
         OP_READ_SCREEN: exec_written = 1'b0;
         default:        exec_written = 1'b0;
      endcase
      priority if (cur_item_ff.op == OP_CLEAR) begin
         exec_out = CLEAR_CELL;
      end else if (!cur_item_ff.in_view) begin
         exec_out = '0;
      end else begin
         exec_out = exec_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_item_ff <= q_item;
         cur_addr_ff <= q_addr;
      end
      if (load_out) begin
         out_written_ff <= exec_written;
         out_in_view_ff <= cur_item_ff.in_view;
         out_cell_ff    <= exec_out;
      end
   end

   // cell memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (q_pop) begin
         rd_cell_ff <= mem[q_addr];
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.written    = out_written_ff;
   assign rsp_chan.in_view    = out_in_view_ff;
   assign rsp_chan.cell_red   = out_cell_ff.red;
   assign rsp_chan.cell_green = out_cell_ff.green;
   assign rsp_chan.cell_blue  = out_cell_ff.blue;
   assign rsp_chan.cell_depth = out_cell_ff.depth;
   assign rsp_chan.cell_id    = out_cell_ff.id;

endmodule

// ----- rtl/core/depth_tested_alpha_pixel_writer.sv -----
// A request passes the queue, the back end's item and cell registers and the response
// register, which loads once the output is free. The back end takes a new request only
// after the last has left, as it reads each cell and then writes it; the two-entry queue
// keeps accepting, until full, while the back end or output stalls. Reset (synchronous,
// active high) clears control state and sweeps all VIEW_WIDTH*VIEW_HEIGHT cells clear with
// req_chan.ready low; a clear request runs the same sweep after its response is loaded.
module depth_tested_alpha_pixel_writer #(
   parameter int VIEW_WIDTH  = 256,
   parameter int VIEW_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   dtapw_req_if.sink                         req_chan,
   dtapw_rsp_if.source                       rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [dtapw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dtapw_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import dtapw_pkg::*;

   localparam int ADDR_W = $clog2(VIEW_WIDTH * VIEW_HEIGHT);
   localparam int QDATA_W = $bits(item_type) + ADDR_W;

   // front -> queue
   logic               push;
   item_type           push_item;
   logic [ADDR_W-1:0]  push_addr;
   logic               q_full;

   // queue -> back
   logic               q_valid;
   logic               q_pop;
   logic [QDATA_W-1:0] q_data;
   item_type           q_item;
   logic [ADDR_W-1:0]  q_addr;

   // back -> front: hold off requests while cells are being cleared
   logic               sweeping;

   dtapw_front #(
      .VIEW_WIDTH  (VIEW_WIDTH),
      .VIEW_HEIGHT (VIEW_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .sweeping    (sweeping),
      .q_full      (q_full),
      .push        (push),
      .push_item   (push_item),
      .push_addr   (push_addr)
   );

   dtapw_queue #(
      .DATA_W (QDATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_addr, push_item}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .data      (q_data)
   );

   // split the queue word back into address and request fields
   assign q_item = q_data[$bits(item_type)-1:0];
   assign q_addr = q_data[QDATA_W-1:$bits(item_type)];

   dtapw_back #(
      .VIEW_WIDTH  (VIEW_WIDTH),
      .VIEW_HEIGHT (VIEW_HEIGHT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_addr   (q_addr),
      .q_pop    (q_pop),
      .sweeping (sweeping),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- rtl/core/dtapw_checker.sv -----
// Port-level checks for the pixel writer, attached to the top level by bind.
// Depends on dtapw_pkg and the top level depth_tested_alpha_pixel_writer.
module dtapw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_written,
   input logic        rsp_in_view,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue,
   input logic [31:0] rsp_depth,
   input logic [31:0] rsp_id
);
   import dtapw_pkg::*;

   // reset starts the clearing sweep: no requests taken, no response shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request or response channel active right after reset");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_written, rsp_in_view, rsp_red, rsp_green, rsp_blue,
                     rsp_depth, rsp_id}))
      else $error("response changed while stalled");

   // out-of-view response carries an empty cell
   a_out_of_view_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_written && !rsp_in_view |->
         rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0
         && rsp_depth == 32'd0 && rsp_id == 32'd0)
      else $error("out-of-view response has nonzero cell fields");

   // clear response shows the cleared cell
   a_clear_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written && !rsp_in_view |->
         rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0
         && rsp_depth == DEPTH_MIN && rsp_id == 32'd0)
      else $error("clear response does not show the cleared cell");

endmodule

bind depth_tested_alpha_pixel_writer dtapw_checker u_dtapw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_written (rsp_chan.written),
   .rsp_in_view (rsp_chan.in_view),
   .rsp_red     (rsp_chan.cell_red),
   .rsp_green   (rsp_chan.cell_green),
   .rsp_blue    (rsp_chan.cell_blue),
   .rsp_depth   (rsp_chan.cell_depth),
   .rsp_id      (rsp_chan.cell_id)
);
